/* rtl/core/irpdc_pkg.sv */
package irpdc_pkg;

  localparam int MAX_PAIRS    = 512;
  localparam int DICT_ENTRIES = 8;
  localparam int TABLE_BYTES  = 64;
  localparam int HDR_BYTES    = 10;

  localparam int DICT_IW    = (DICT_ENTRIES > 1) ? $clog2(DICT_ENTRIES) : 1;
  localparam int DICT_CW    = $clog2(DICT_ENTRIES + 1);
  localparam int PAIR_CW    = $clog2(MAX_PAIRS + 1);
  localparam int PACK_DEPTH = (MAX_PAIRS + 1) / 2;
  localparam int PACK_AW    = (PACK_DEPTH > 1) ? $clog2(PACK_DEPTH) : 1;
  localparam int FRAME_CAP  = HDR_BYTES + TABLE_BYTES + PACK_DEPTH;
  localparam int FP_W       = $clog2(FRAME_CAP + 1);
  localparam int TABLE_ENTS = TABLE_BYTES / 4;

  localparam logic [7:0] CRC_POLY   = 8'h8C;
  localparam logic [7:0] FRAME_MARK = 8'h54;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_OVERFLOW = 1'b1;

  // header byte positions
  localparam logic [3:0] HB_MARK   = 4'd0;
  localparam logic [3:0] HB_LEN_HI = 4'd1;
  localparam logic [3:0] HB_LEN_LO = 4'd2;
  localparam logic [3:0] HB_CARR   = 4'd3;
  localparam logic [3:0] HB_CNT_HI = 4'd4;
  localparam logic [3:0] HB_CNT_LO = 4'd5;
  localparam logic [3:0] HB_VER    = 4'd8;
  localparam logic [3:0] HB_CRC    = 4'd9;

  typedef struct packed {
    logic               hit;
    logic [DICT_IW-1:0] idx;
  } dict_res_t;

  function automatic logic near_one(logic [15:0] a, logic [15:0] b);
    logic [16:0] d;
    d = {1'b0, a} - {1'b0, b};
    return (d == 17'd0) || (d == 17'd1) || (d == 17'h1FFFF);
  endfunction

  function automatic logic [7:0] crc8_step(logic [7:0] c, logic [7:0] b);
    logic [7:0] r;
    r = c ^ b;
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

/* rtl/core/irpdc_if.sv */
interface irpdc_pair_if;
  logic        valid;
  logic        ready;
  logic [15:0] mark_cycles;
  logic [15:0] space_cycles;
  logic        last_pair;

  modport source (output valid, mark_cycles, space_cycles, last_pair, input ready);
  modport sink   (input valid, mark_cycles, space_cycles, last_pair, output ready);
endinterface

interface irpdc_word_if;
  logic        valid;
  logic        ready;
  logic [63:0] frame_word;
  logic [3:0]  valid_bytes;
  logic        last_word;
  logic        status;

  modport source (output valid, frame_word, valid_bytes, last_word, status, input ready);
  modport sink   (input valid, frame_word, valid_bytes, last_word, status, output ready);
endinterface

/* rtl/core/irpdc_cell.sv */
module irpdc_cell
  import irpdc_pkg::*;
(
  input  logic               clk,
  input  logic [DICT_IW-1:0] cell_id,
  input  logic [DICT_CW-1:0] used,
  input  logic               wr_en,
  input  logic [15:0]        mark,
  input  logic [15:0]        space,
  input  logic               hit_in,
  output logic               hit_out,
  output logic               sel,
  output logic [31:0]        entry
);

  logic active;
  logic match;

  assign active  = DICT_CW'(cell_id) < used;
  assign match   = active && near_one(mark, entry[31:16]) && near_one(space, entry[15:0]);
  assign sel     = match && !hit_in;
  assign hit_out = hit_in || match;

  always_ff @(posedge clk) begin
    if (wr_en && (DICT_CW'(cell_id) == used)) begin
      entry <= {mark, space};
    end
  end

endmodule

/* rtl/core/irpdc_dict.sv */
module irpdc_dict
  import irpdc_pkg::*;
(
  input  logic               clk,
  input  logic [DICT_CW-1:0] used,
  input  logic               wr_en,
  input  logic [15:0]        mark,
  input  logic [15:0]        space,
  output dict_res_t          res,
  output logic [31:0]        entries [DICT_ENTRIES]
);

  logic [DICT_ENTRIES:0]   hit_c;
  logic [DICT_ENTRIES-1:0] sel;

  assign hit_c[0] = 1'b0;

  for (genvar k = 0; k < DICT_ENTRIES; k++) begin : g_cell
    irpdc_cell u_cell (
      .clk     (clk),
      .cell_id (DICT_IW'(k)),
      .used    (used),
      .wr_en   (wr_en),
      .mark    (mark),
      .space   (space),
      .hit_in  (hit_c[k]),
      .hit_out (hit_c[k+1]),
      .sel     (sel[k]),
      .entry   (entries[k])
    );
  end

  always_comb begin
    res.hit = hit_c[DICT_ENTRIES];
    res.idx = '0;
    for (int k = 0; k < DICT_ENTRIES; k++) begin
      if (sel[k]) begin
        res.idx = res.idx | DICT_IW'(k);
      end
    end
  end

endmodule

/* rtl/core/ir_pattern_dictionary_compressor.sv */
// ir pair dictionary compressor: each accepted mark/space pair is compared
// combinationally against a chain of dictionary cells (match = both halves
// within 1 of the entry, lowest cell wins) and its entry index is packed two
// per byte into an index ram; pairs are taken one per cycle while a frame is
// being collected. after the pair flagged last_pair the block stops taking
// pairs and walks the frame byte by byte, a fetch state then a use state per
// byte (the index ram read is registered): first over the body for the crc-8,
// then over the whole frame to build the 8-byte output words, holding on any
// output stall; the frame is 10 + 64 + ceil(pairs/2) bytes. a ninth distinct
// pair marks the frame as overflowed; it then ends with one word of status 1,
// valid_bytes 0. carrier_code is written through cfg_wen/cfg_wdata; the user
// must write it only while the block is idle, which the block does not enforce.
module ir_pattern_dictionary_compressor
  import irpdc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wen,
  input  logic [7:0]          cfg_wdata,
  irpdc_pair_if.sink          pairs,
  irpdc_word_if.source        words
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIN,
    ST_CRC_FETCH,
    ST_CRC_USE,
    ST_EM_FETCH,
    ST_EM_USE
  } state_t;

  state_t             state;
  logic [7:0]         carrier_code;
  logic [DICT_CW-1:0] dict_used;
  logic [PAIR_CW-1:0] pairs_cnt;
  logic               overflow;
  logic [3:0]         pend_nib;
  logic [7:0]         crc;
  logic [FP_W-1:0]    fp;
  logic [63:0]        wbuf;
  logic [3:0]         wcnt;

  // packed index ram
  logic [7:0]         pack_mem [PACK_DEPTH];
  logic [7:0]         rd_data;
  logic [PACK_AW-1:0] rd_addr;
  logic [PACK_AW-1:0] wr_addr;
  logic               mem_we;

  dict_res_t          res;
  logic [31:0]        entries [DICT_ENTRIES];
  logic               accept;
  logic               take;
  logic               dict_we;
  logic [DICT_IW-1:0] new_idx;

  logic [FP_W-1:0]    length;
  logic [FP_W-1:0]    body_t;
  logic [FP_W-1:0]    pk;
  logic [FP_W-1:0]    ent;
  logic [31:0]        ent_word;
  logic [7:0]         cur_byte;
  logic [63:0]        wbuf_next;
  logic               out_free;
  logic               word_full;
  logic               byte_end;
  logic               word_load;

  assign accept  = pairs.valid && pairs.ready;
  assign take    = !overflow && (pairs_cnt < PAIR_CW'(MAX_PAIRS));
  assign dict_we = accept && take && !res.hit && (dict_used < DICT_CW'(DICT_ENTRIES));
  assign new_idx = res.hit ? res.idx : DICT_IW'(dict_used);
  assign mem_we  = accept && take && (res.hit || dict_we) && pairs_cnt[0];
  assign wr_addr = PACK_AW'(pairs_cnt >> 1);

  assign pairs.ready = (state == ST_IDLE);

  irpdc_dict u_dict (
    .clk     (clk),
    .used    (dict_used),
    .wr_en   (dict_we),
    .mark    (pairs.mark_cycles),
    .space   (pairs.space_cycles),
    .res     (res),
    .entries (entries)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pack_mem[wr_addr] <= {pend_nib, 4'(new_idx)};
    end
    rd_data <= pack_mem[rd_addr];
  end

  // byte of the frame at position fp
  always_comb begin
    length   = FP_W'(HDR_BYTES + TABLE_BYTES) + FP_W'((PAIR_CW'(1) + pairs_cnt) >> 1);
    body_t   = fp - FP_W'(HDR_BYTES);
    pk       = body_t - FP_W'(TABLE_BYTES);
    rd_addr  = PACK_AW'(pk);
    ent      = body_t >> 2;
    ent_word = entries[DICT_IW'(ent)];
    cur_byte = 8'h00;
    if (fp < FP_W'(HDR_BYTES)) begin
      case (fp[3:0])
        HB_MARK:   cur_byte = FRAME_MARK;
        HB_LEN_HI: cur_byte = 8'(16'(length) >> 8);
        HB_LEN_LO: cur_byte = 8'(length);
        HB_CARR:   cur_byte = carrier_code;
        HB_CNT_HI: cur_byte = 8'(16'(pairs_cnt) >> 8);
        HB_CNT_LO: cur_byte = 8'(pairs_cnt);
        HB_VER:    cur_byte = 8'h01;
        HB_CRC:    cur_byte = crc;
        default:   cur_byte = 8'h00;
      endcase
    end else if (body_t < FP_W'(TABLE_BYTES)) begin
      // table region, zero past the used entries
      if ((ent < FP_W'(dict_used)) && (ent < FP_W'(TABLE_ENTS))) begin
        case (body_t[1:0])
          2'd0:    cur_byte = ent_word[31:24];
          2'd1:    cur_byte = ent_word[23:16];
          2'd2:    cur_byte = ent_word[15:8];
          default: cur_byte = ent_word[7:0];
        endcase
      end
    end else if (pairs_cnt[0] && (pk == FP_W'(pairs_cnt >> 1))) begin
      // odd count: lone index still waiting in the pending nibble
      cur_byte = {pend_nib, 4'h0};
    end else begin
      cur_byte = rd_data;
    end
  end

  assign out_free  = !words.valid || words.ready;
  assign wbuf_next = wbuf | (64'(cur_byte) << {~wcnt[2:0], 3'b000});
  assign word_full = (wcnt == 4'd7);
  assign byte_end  = (fp == length - FP_W'(1));
  // a word goes into the output register this cycle
  assign word_load = out_free && (((state == ST_FIN) && overflow) ||
                                  ((state == ST_EM_USE) && (word_full || byte_end)));

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      carrier_code      <= 8'h00;
      dict_used         <= '0;
      pairs_cnt         <= '0;
      overflow          <= 1'b0;
      pend_nib          <= 4'h0;
      crc               <= 8'h00;
      fp                <= '0;
      wbuf              <= '0;
      wcnt              <= '0;
      words.valid       <= 1'b0;
      words.frame_word  <= '0;
      words.valid_bytes <= '0;
      words.last_word   <= 1'b0;
      words.status      <= STATUS_OK;
    end else begin
      if (cfg_wen) begin
        carrier_code <= cfg_wdata;
      end
      if (word_load) begin
        words.valid <= 1'b1;
      end else if (words.valid && words.ready) begin
        words.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (take) begin
              if (res.hit || dict_we) begin
                if (dict_we) begin
                  dict_used <= dict_used + DICT_CW'(1);
                end
                if (!pairs_cnt[0]) begin
                  pend_nib <= 4'(new_idx);
                end
                pairs_cnt <= pairs_cnt + PAIR_CW'(1);
              end else begin
                overflow <= 1'b1;
              end
            end
            if (pairs.last_pair) begin
              state <= ST_FIN;
            end
          end
        end
        ST_FIN: begin
          if (overflow) begin
            if (out_free) begin
              words.frame_word  <= '0;
              words.valid_bytes <= 4'd0;
              words.last_word   <= 1'b1;
              words.status      <= STATUS_OVERFLOW;
              dict_used         <= '0;
              pairs_cnt         <= '0;
              overflow          <= 1'b0;
              state             <= ST_IDLE;
            end
          end else begin
            crc   <= 8'h00;
            fp    <= FP_W'(HDR_BYTES);
            state <= ST_CRC_FETCH;
          end
        end
        ST_CRC_FETCH: begin
          state <= ST_CRC_USE;
        end
        ST_CRC_USE: begin
          crc <= crc8_step(crc, cur_byte);
          if (byte_end) begin
            fp    <= '0;
            state <= ST_EM_FETCH;
          end else begin
            fp    <= fp + FP_W'(1);
            state <= ST_CRC_FETCH;
          end
        end
        ST_EM_FETCH: begin
          state <= ST_EM_USE;
        end
        ST_EM_USE: begin
          if (word_full || byte_end) begin
            // hold here until the output word register frees up
            if (out_free) begin
              words.frame_word  <= wbuf_next;
              words.valid_bytes <= wcnt + 4'd1;
              words.last_word   <= byte_end;
              words.status      <= STATUS_OK;
              wbuf              <= '0;
              wcnt              <= '0;
              if (byte_end) begin
                dict_used <= '0;
                pairs_cnt <= '0;
                overflow  <= 1'b0;
                state     <= ST_IDLE;
              end else begin
                fp    <= fp + FP_W'(1);
                state <= ST_EM_FETCH;
              end
            end
          end else begin
            wbuf  <= wbuf_next;
            wcnt  <= wcnt + 4'd1;
            fp    <= fp + FP_W'(1);
            state <= ST_EM_FETCH;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // an overflow word is always the only and final word of its frame
  a_ovf_last: assert property (@(posedge clk) disable iff (rst)
    (words.valid && (words.status == STATUS_OVERFLOW)) |-> words.last_word)
    else $error("overflow word without last_word");

  a_pair_cap: assert property (@(posedge clk) disable iff (rst)
    pairs_cnt <= PAIR_CW'(MAX_PAIRS))
    else $error("pair count beyond capacity");

  a_dict_cap: assert property (@(posedge clk) disable iff (rst)
    dict_used <= DICT_CW'(DICT_ENTRIES))
    else $error("dictionary fill beyond its entries");

  // the pair that ends a frame closes the input until the frame is out
  a_end_closes: assert property (@(posedge clk) disable iff (rst)
    (accept && pairs.last_pair) |=> !pairs.ready)
    else $error("pairs taken right after frame end");

endmodule

/* tb/tb_top.sv */
module tb_top;
  import irpdc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD = 3000;

  // one input word: a mark/space pair
  typedef struct {
    logic [15:0] mark;
    logic [15:0] space;
    logic        last;
  } pair_t;

  // one output word of a frame
  typedef struct {
    logic [63:0] data;
    logic [3:0]  nbytes;
    logic        last;
    logic        status;
  } frame_word_t;

  logic clk;
  logic rst;
  logic cfg_wen;
  logic [7:0] cfg_wdata;

  irpdc_pair_if pif ();
  irpdc_word_if wif ();

  ir_pattern_dictionary_compressor dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .pairs     (pif),
    .words     (wif)
  );

  // pairs waiting to be offered, and frame words still owed by the block
  pair_t       pending_pairs[$];
  frame_word_t owed_words[$];

  // shadow of the compressor state
  logic [31:0] shadow_dict[DICT_ENTRIES];
  int          shadow_used;
  logic [3:0]  shadow_idx[MAX_PAIRS];
  int          shadow_count;
  bit          shadow_ovf;
  logic [7:0]  shadow_carrier;
  logic [7:0]  frame_bytes[FRAME_CAP];

  int  mismatches;
  int  cycles;
  int  tx_gap;
  int  rx_gap;
  int  rx_hold_left;
  bit  rx_hold_req;
  bit  tx_calm;
  bit  rx_calm;
  pair_t cur_pair;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic bit within_one(logic [15:0] a, logic [15:0] b);
    int d;
    d = (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
    return d <= 1;
  endfunction

  function automatic logic [7:0] crc_byte(logic [7:0] c, logic [7:0] b);
    logic [7:0] r;
    r = c ^ b;
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ 8'h8C) : (r >> 1);
    end
    return r;
  endfunction

  function automatic void clear_shadow();
    shadow_used = 0;
    shadow_count = 0;
    shadow_ovf = 0;
  endfunction

  // step the shadow state by one accepted pair, queue the words it causes
  function automatic void compress_pair(pair_t p);
    int hit;
    int packed_n;
    int body;
    int total;
    int nwords;
    int cnt;
    logic [7:0] crc;
    frame_word_t fw;
    if (!shadow_ovf && shadow_count < MAX_PAIRS) begin
      hit = -1;
      for (int k = 0; k < shadow_used; k++) begin
        if (hit < 0 && within_one(p.mark, shadow_dict[k][31:16]) &&
            within_one(p.space, shadow_dict[k][15:0])) hit = k;
      end
      if (hit < 0) begin
        if (shadow_used < DICT_ENTRIES) begin
          hit = shadow_used;
          shadow_dict[hit] = {p.mark, p.space};
          shadow_used++;
        end else begin
          shadow_ovf = 1;
        end
      end
      if (!shadow_ovf) begin
        shadow_idx[shadow_count] = hit[3:0];
        shadow_count++;
      end
    end
    if (!p.last) return;
    if (shadow_ovf) begin
      fw.data = '0;
      fw.nbytes = '0;
      fw.last = 1'b1;
      fw.status = STATUS_OVERFLOW;
      owed_words.push_back(fw);
      clear_shadow();
      return;
    end
    packed_n = (shadow_count + 1) / 2;
    body = TABLE_BYTES + packed_n;
    total = body + HDR_BYTES;
    for (int i = 0; i < FRAME_CAP; i++) frame_bytes[i] = 8'h00;
    // dictionary table, entries that do not fit are left out
    for (int k = 0; k < shadow_used; k++) begin
      if (4 * k + 3 < TABLE_BYTES) begin
        frame_bytes[HDR_BYTES + 4 * k]     = shadow_dict[k][31:24];
        frame_bytes[HDR_BYTES + 4 * k + 1] = shadow_dict[k][23:16];
        frame_bytes[HDR_BYTES + 4 * k + 2] = shadow_dict[k][15:8];
        frame_bytes[HDR_BYTES + 4 * k + 3] = shadow_dict[k][7:0];
      end
    end
    // packed indices, earlier one in the high nibble
    for (int k = 0; k < shadow_count; k++) begin
      if (k % 2 == 0)
        frame_bytes[HDR_BYTES + TABLE_BYTES + k / 2] = {shadow_idx[k], 4'h0};
      else
        frame_bytes[HDR_BYTES + TABLE_BYTES + k / 2][3:0] = shadow_idx[k];
    end
    crc = 8'h00;
    for (int k = 0; k < body; k++) crc = crc_byte(crc, frame_bytes[HDR_BYTES + k]);
    frame_bytes[0] = 8'h54;
    frame_bytes[1] = total[15:8];
    frame_bytes[2] = total[7:0];
    frame_bytes[3] = shadow_carrier;
    frame_bytes[4] = shadow_count[15:8];
    frame_bytes[5] = shadow_count[7:0];
    frame_bytes[6] = 8'h00;
    frame_bytes[7] = 8'h00;
    frame_bytes[8] = 8'h01;
    frame_bytes[9] = crc;
    nwords = (total + 7) / 8;
    for (int k = 0; k < nwords; k++) begin
      cnt = total - 8 * k;
      if (cnt > 8) cnt = 8;
      fw.data = '0;
      for (int b = 0; b < 8; b++) begin
        fw.data = {fw.data[55:0], (b < cnt) ? frame_bytes[8 * k + b] : 8'h00};
      end
      fw.nbytes = cnt[3:0];
      fw.last = (k + 1 == nwords);
      fw.status = STATUS_OK;
      owed_words.push_back(fw);
    end
    clear_shadow();
  endfunction

  // pair driver
  always @(posedge clk) begin
    if (rst) begin
      pif.valid <= 1'b0;
      tx_gap <= 0;
    end else begin
      if (pif.valid && pif.ready) compress_pair(cur_pair);
      if (pif.valid && !pif.ready) begin
        // hold the offered pair
      end else if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
        pif.valid <= 1'b0;
      end else if (pending_pairs.size() > 0) begin
        cur_pair = pending_pairs.pop_front();
        pif.mark_cycles <= cur_pair.mark;
        pif.space_cycles <= cur_pair.space;
        pif.last_pair <= cur_pair.last;
        pif.valid <= 1'b1;
        if ($urandom_range(0, 15) == 0) tx_calm = ~tx_calm;
        tx_gap <= tx_calm ? 0 : $urandom_range(0, 16);
      end else begin
        pif.valid <= 1'b0;
      end
    end
  end

  // word monitor and checker
  always @(posedge clk) begin
    frame_word_t want;
    int g;
    if (rst) begin
      wif.ready <= 1'b0;
      rx_gap <= 0;
      rx_hold_left <= 0;
    end else begin
      if (wif.valid && wif.ready) begin
        if (owed_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word %h bytes %0d last %b status %b", wif.frame_word,
                     wif.valid_bytes, wif.last_word, wif.status);
        end else begin
          want = owed_words.pop_front();
          if (wif.frame_word !== want.data || wif.valid_bytes !== want.nbytes ||
              wif.last_word !== want.last || wif.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("word mismatch: exp %h/%0d/%b/%b got %h/%0d/%b/%b", want.data,
                       want.nbytes, want.last, want.status, wif.frame_word,
                       wif.valid_bytes, wif.last_word, wif.status);
          end
        end
      end
      // long hold-off on request, so the block backs up into its input
      if (rx_hold_req) begin
        rx_hold_req = 0;
        rx_hold_left <= LONG_HOLD;
        wif.ready <= 1'b0;
      end else if (rx_hold_left > 0) begin
        rx_hold_left <= rx_hold_left - 1;
        wif.ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        wif.ready <= 1'b0;
      end else if (wif.valid && wif.ready) begin
        if ($urandom_range(0, 15) == 0) rx_calm = ~rx_calm;
        g = rx_calm ? 0 : $urandom_range(0, 16);
        if (g > 0) begin
          rx_gap <= g - 1;
          wif.ready <= 1'b0;
        end else begin
          wif.ready <= 1'b1;
        end
      end else begin
        wif.ready <= 1'b1;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic add_pair(int m, int s, bit l);
    pair_t p;
    p.mark = m[15:0];
    p.space = s[15:0];
    p.last = l;
    pending_pairs.push_back(p);
  endtask

  // sender pauses until every owed word has come and the block is quiet
  task automatic wait_quiet();
    while (pending_pairs.size() != 0 || pif.valid || owed_words.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_carrier(logic [7:0] v);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= v;
    shadow_carrier = v;
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  // one random frame built around a few prototype pairs with jitter
  task automatic add_random_frame(output int n);
    int protos;
    int pm[9];
    int ps[9];
    int j;
    n = $urandom_range(1, 24);
    protos = $urandom_range(1, 9);
    for (int i = 0; i < protos; i++) begin
      pm[i] = $urandom_range(0, 65535);
      ps[i] = $urandom_range(0, 65535);
      if ($urandom_range(0, 3) == 0) pm[i] = $urandom_range(0, 1) ? 0 : 65535;
    end
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        add_pair($urandom_range(0, 65535), $urandom_range(0, 65535), i == n - 1);
      end else begin
        j = $urandom_range(0, protos - 1);
        add_pair((pm[j] + $urandom_range(0, 4) - 2) & 16'hFFFF,
                 (ps[j] + $urandom_range(0, 4) - 2) & 16'hFFFF, i == n - 1);
      end
    end
  endtask

  initial begin
    int sent;
    int n;
    pif.valid = 1'b0;
    pif.mark_cycles = '0;
    pif.space_cycles = '0;
    pif.last_pair = 1'b0;
    wif.ready = 1'b0;
    cfg_wen = 1'b0;
    cfg_wdata = '0;
    mismatches = 0;
    cycles = 0;
    tx_calm = 0;
    rx_calm = 0;
    rx_hold_req = 0;
    shadow_carrier = 8'h00;
    clear_shadow();
    rst = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: one pair alone, odd count
    set_carrier(8'h00);
    add_pair(0, 0, 1);
    wait_quiet();
    // extremes, near matches, wrap of 0 against 65535 not near
    set_carrier(8'hFF);
    add_pair(65535, 65535, 0);
    add_pair(65534, 0, 0);
    add_pair(65535, 1, 0);
    add_pair(0, 65535, 0);
    add_pair(1, 65534, 0);
    add_pair(100, 200, 0);
    add_pair(101, 199, 0);
    add_pair(102, 200, 1);
    wait_quiet();
    // dictionary overflow: ninth distinct pair, later pairs ignored
    for (int i = 0; i < 9; i++) add_pair(i * 1000, i * 1000 + 7, 0);
    add_pair(5, 5, 0);
    add_pair(0, 7, 1);
    wait_quiet();
    // capacity: pairs beyond the index store are dropped
    set_carrier(8'h5A);
    for (int i = 0; i < MAX_PAIRS + 8; i++)
      add_pair((i % 3) * 300, 40000 + (i % 3), i == MAX_PAIRS + 7);
    wait_quiet();

    // random frames; the first group runs under a long output hold-off
    sent = 0;
    @(negedge clk);
    rx_hold_req = 1;
    for (int grp = 0; sent < 100; grp++) begin
      for (int f = 0; f < 3; f++) begin
        add_random_frame(n);
        sent += n;
      end
      wait_quiet();
      set_carrier($urandom_range(0, 255));
    end
    wait_quiet();

    if (mismatches == 0 && owed_words.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
